/* hw/rtl/record_quicksort_engine_core_macros.svh */
// Assertion helpers used by the top-level RTL file of the quicksort engine.
`ifndef RECORD_QUICKSORT_ENGINE_CORE_MACROS_SVH
`define RECORD_QUICKSORT_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RQS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RQS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/rqs_pkg.sv */
package rqs_pkg;

  // Store geometry
  localparam int ENTRIES     = 64;
  localparam int KEY_BITS    = 64;
  localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W       = IDX_W + 1;
  localparam int STACK_DEPTH = 64;
  localparam int STK_IDX_W   = $clog2(STACK_DEPTH);
  localparam int SP_W        = STK_IDX_W + 1;

  // Stream field widths
  localparam int KEY_W  = 64;
  localparam int TAG_W  = 8;
  localparam int KIND_W = 2;
  localparam int S_DATA_W = 80;
  localparam int M_DATA_W = 72;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_SORT  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  // Source of the record memory write data
  typedef enum logic [1:0] {
    WR_IN = 2'd0,
    WR_A  = 2'd1,
    WR_B  = 2'd2
  } wr_src_e;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_W-1:0]    tag;
  } rec_t;

  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } range_t;

  // Controller to datapath
  typedef struct packed {
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    wr_src_e              wr_src;
    logic                 cap_a;
    logic                 cap_b;
    logic                 cap_pivot;
    logic                 out_load;
    logic                 out_last;
    logic [STK_IDX_W-1:0] stk_rd_addr;
    logic                 stk_wr_en;
    logic [STK_IDX_W-1:0] stk_wr_addr;
    range_t               stk_wr_data;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic   less;
    logic   out_free;
    range_t stk_rd;
  } stat_t;

endpackage

/* hw/rtl/rqs_datapath.sv */
module rqs_datapath import rqs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  rec_t                in_rec_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [KEY_W-1:0]    out_key_o,
  output logic [TAG_W-1:0]    out_tag_o,
  output logic                out_last_o,
  output stat_t               stat_o
);

  rec_t   rec_mem [ENTRIES];
  range_t stk_mem [STACK_DEPTH];

  rec_t   rd_q;
  range_t stk_rd_q;
  rec_t   a_q, b_q;
  logic [KEY_BITS-1:0] pivot_q;
  rec_t   out_rec_q;
  logic   out_last_q;
  logic   out_valid_q;
  rec_t   wr_data;

  // Record write data select
  always_comb begin
    case (cmd_i.wr_src)
      WR_IN:   wr_data = in_rec_i;
      WR_A:    wr_data = a_q;
      WR_B:    wr_data = b_q;
      default: wr_data = in_rec_i;
    endcase
  end

  // Record memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      rec_mem[cmd_i.wr_addr] <= wr_data;
    end
    rd_q <= rec_mem[cmd_i.rd_addr];
  end

  // Range stack memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.stk_wr_en) begin
      stk_mem[cmd_i.stk_wr_addr] <= cmd_i.stk_wr_data;
    end
    stk_rd_q <= stk_mem[cmd_i.stk_rd_addr];
  end

  // Swap holding registers and pivot
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_a) begin
      a_q <= rd_q;
    end
    if (cmd_i.cap_b) begin
      b_q <= rd_q;
    end
    if (cmd_i.cap_pivot) begin
      pivot_q <= rd_q.key;
    end
    if (cmd_i.out_load) begin
      out_rec_q  <= rd_q;
      out_last_q <= cmd_i.out_last;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.less     = rd_q.key < pivot_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign stat_o.stk_rd   = stk_rd_q;

  assign out_valid_o = out_valid_q;
  assign out_key_o   = KEY_W'(out_rec_q.key);
  assign out_tag_o   = out_rec_q.tag;
  assign out_last_o  = out_last_q;

endmodule

/* hw/rtl/rqs_ctrl.sv */
module rqs_ctrl import rqs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [KIND_W-1:0] in_kind_i,
  input  logic              in_desc_i,
  output logic              in_ready_o,
  input  stat_t             stat_i,
  output cmd_t              cmd_o
);

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_POP     = 5'd1;
  localparam logic [4:0] ST_POP_W   = 5'd2;
  localparam logic [4:0] ST_PIV_RD  = 5'd3;
  localparam logic [4:0] ST_PIV_CAP = 5'd4;
  localparam logic [4:0] ST_SCAN_RD = 5'd5;
  localparam logic [4:0] ST_CMP     = 5'd6;
  localparam logic [4:0] ST_SW_CA   = 5'd7;
  localparam logic [4:0] ST_SW_WJ   = 5'd8;
  localparam logic [4:0] ST_FIN_RA  = 5'd9;
  localparam logic [4:0] ST_FIN_RB  = 5'd10;
  localparam logic [4:0] ST_FIN_CB  = 5'd11;
  localparam logic [4:0] ST_FIN_W1  = 5'd12;
  localparam logic [4:0] ST_FIN_W2  = 5'd13;
  localparam logic [4:0] ST_PUSH_R  = 5'd14;
  localparam logic [4:0] ST_PUSH_L  = 5'd15;
  localparam logic [4:0] ST_EM_RD   = 5'd16;
  localparam logic [4:0] ST_EM_LD   = 5'd17;

  logic [4:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [SP_W-1:0]  sp_q, sp_d;
  logic             desc_q, desc_d;
  logic [IDX_W-1:0] lo_q, lo_d, hi_q, hi_d, p_q, p_d, j_q, j_d, k_q, k_d;

  logic [SP_W-1:0]  sp_dec;
  logic [CNT_W-1:0] count_dec;
  logic [IDX_W:0]   p_inc, lo_inc, k_inc;
  logic             stk_room;
  logic             em_last;

  assign sp_dec    = sp_q - SP_W'(1);
  assign count_dec = count_q - CNT_W'(1);
  assign p_inc     = {1'b0, p_q} + (IDX_W+1)'(1);
  assign lo_inc    = {1'b0, lo_q} + (IDX_W+1)'(1);
  assign k_inc     = {1'b0, k_q} + (IDX_W+1)'(1);
  assign stk_room  = sp_q < SP_W'(STACK_DEPTH);
  assign em_last   = CNT_W'(k_inc) == count_q;

  // Next-state and command logic
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    sp_d    = sp_q;
    desc_d  = desc_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    p_d     = p_q;
    j_d     = j_q;
    k_d     = k_q;
    cmd_o   = '0;
    cmd_o.wr_src = WR_IN;
    in_ready_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (kind_e'(in_kind_i))
            KIND_LOAD: begin
              if (count_q < CNT_W'(ENTRIES)) begin
                cmd_o.wr_en   = 1'b1;
                cmd_o.wr_addr = count_q[IDX_W-1:0];
                cmd_o.wr_src  = WR_IN;
                count_d       = count_q + CNT_W'(1);
              end
            end
            KIND_CLEAR: begin
              count_d = '0;
            end
            KIND_SORT: begin
              desc_d = in_desc_i;
              k_d    = '0;
              if (count_q > CNT_W'(1)) begin
                // seed the stack with the whole store
                cmd_o.stk_wr_en      = 1'b1;
                cmd_o.stk_wr_addr    = '0;
                cmd_o.stk_wr_data.lo = '0;
                cmd_o.stk_wr_data.hi = count_dec[IDX_W-1:0];
                sp_d    = SP_W'(1);
                state_d = ST_POP;
              end else if (count_q == CNT_W'(1)) begin
                state_d = ST_EM_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_POP: begin
        if (sp_q == '0) begin
          k_d     = '0;
          state_d = ST_EM_RD;
        end else begin
          cmd_o.stk_rd_addr = sp_dec[STK_IDX_W-1:0];
          sp_d    = sp_dec;
          state_d = ST_POP_W;
        end
      end
      ST_POP_W: begin
        lo_d    = stat_i.stk_rd.lo;
        hi_d    = stat_i.stk_rd.hi;
        state_d = ST_PIV_RD;
      end
      ST_PIV_RD: begin
        cmd_o.rd_addr = hi_q;
        p_d     = lo_q;
        j_d     = lo_q;
        state_d = ST_PIV_CAP;
      end
      ST_PIV_CAP: begin
        cmd_o.cap_pivot = 1'b1;
        state_d = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        if (j_q == hi_q) begin
          state_d = ST_FIN_RA;
        end else begin
          cmd_o.rd_addr = j_q;
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        // element j moves left when the order test holds
        if (stat_i.less ^ desc_q) begin
          cmd_o.cap_b   = 1'b1;
          cmd_o.rd_addr = p_q;
          state_d = ST_SW_CA;
        end else begin
          j_d     = j_q + IDX_W'(1);
          state_d = ST_SCAN_RD;
        end
      end
      ST_SW_CA: begin
        cmd_o.cap_a   = 1'b1;
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = p_q;
        cmd_o.wr_src  = WR_B;
        state_d = ST_SW_WJ;
      end
      ST_SW_WJ: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = j_q;
        cmd_o.wr_src  = WR_A;
        p_d     = p_q + IDX_W'(1);
        j_d     = j_q + IDX_W'(1);
        state_d = ST_SCAN_RD;
      end
      ST_FIN_RA: begin
        cmd_o.rd_addr = p_q;
        state_d = ST_FIN_RB;
      end
      ST_FIN_RB: begin
        cmd_o.cap_a   = 1'b1;
        cmd_o.rd_addr = hi_q;
        state_d = ST_FIN_CB;
      end
      ST_FIN_CB: begin
        cmd_o.cap_b = 1'b1;
        state_d = ST_FIN_W1;
      end
      ST_FIN_W1: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = p_q;
        cmd_o.wr_src  = WR_B;
        state_d = ST_FIN_W2;
      end
      ST_FIN_W2: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = hi_q;
        cmd_o.wr_src  = WR_A;
        state_d = ST_PUSH_R;
      end
      ST_PUSH_R: begin
        // right part above the pivot
        if ((p_inc < {1'b0, hi_q}) && stk_room) begin
          cmd_o.stk_wr_en      = 1'b1;
          cmd_o.stk_wr_addr    = sp_q[STK_IDX_W-1:0];
          cmd_o.stk_wr_data.lo = p_inc[IDX_W-1:0];
          cmd_o.stk_wr_data.hi = hi_q;
          sp_d = sp_q + SP_W'(1);
        end
        state_d = ST_PUSH_L;
      end
      ST_PUSH_L: begin
        // left part below the pivot, popped first
        if ((lo_inc < {1'b0, p_q}) && stk_room) begin
          cmd_o.stk_wr_en      = 1'b1;
          cmd_o.stk_wr_addr    = sp_q[STK_IDX_W-1:0];
          cmd_o.stk_wr_data.lo = lo_q;
          cmd_o.stk_wr_data.hi = p_q - IDX_W'(1);
          sp_d = sp_q + SP_W'(1);
        end
        state_d = ST_POP;
      end
      ST_EM_RD: begin
        cmd_o.rd_addr = k_q;
        state_d = ST_EM_LD;
      end
      ST_EM_LD: begin
        cmd_o.rd_addr = k_q;
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = em_last;
          if (em_last) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_inc[IDX_W-1:0];
            state_d = ST_EM_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      sp_q    <= '0;
      desc_q  <= 1'b0;
      lo_q    <= '0;
      hi_q    <= '0;
      p_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sp_q    <= sp_d;
      desc_q  <= desc_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      p_q     <= p_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

endmodule

/* hw/rtl/record_quicksort_engine_core.sv */
// Record sort engine: load up to ENTRIES records (key plus 8-bit tag) with kind 0, empty the
// store with kind 2, and with kind 1 sort the store in place by Lomuto quicksort (last element
// of each range as pivot, pending ranges on a stack) and stream every record out in order,
// tlast on the final one; ties come out in the same unstable order as that scheme gives.
// Keys compare unsigned over their low KEY_BITS bits. A load into a full store is dropped.
// A sort runs on one record memory with a single read and a single write port: each range
// needs setup, a pivot fetch and stack pushes, each scanned element a read and a compare,
// and each swap writes both records back; emission reads each record and then waits while
// the output register is still full. The input is taken only while no sort or emission is
// running, but a load or clear may be taken while the final result still waits in the
// output register.
`include "record_quicksort_engine_core_macros.svh"

module record_quicksort_engine_core import rqs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,  // sort_key[63:0], record_tag[71:64],
                                             // descending[72], zero pad [79:73]
  input  logic [KIND_W-1:0]   s_axis_tuser,  // kind[1:0]
  // Output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata,  // out_key[63:0], out_tag[71:64]
  output logic                m_axis_tlast   // last
);

  cmd_t  cmd;
  stat_t stat;
  rec_t  in_rec;
  logic [KEY_W-1:0] out_key;
  logic [TAG_W-1:0] out_tag;

  // Unpack the input transfer; the key keeps its low KEY_BITS bits
  assign in_rec.key = s_axis_tdata[KEY_BITS-1:0];
  assign in_rec.tag = s_axis_tdata[KEY_W +: TAG_W];

  rqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_desc_i  (s_axis_tdata[KEY_W+TAG_W]),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rqs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_rec_i    (in_rec),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_key_o   (out_key),
    .out_tag_o   (out_tag),
    .out_last_o  (m_axis_tlast),
    .stat_o      (stat)
  );

  assign m_axis_tdata = {out_tag, out_key};

  // Checks
  `RQS_ASSERT_IMP(a_out_load_free, clk_i, rst_ni, cmd.out_load, !m_axis_tvalid || m_axis_tready, "output register overwritten while a transfer is pending")
  `RQS_ASSERT_NXT(a_last_to_idle, clk_i, rst_ni, cmd.out_load && cmd.out_last, s_axis_tready, "controller not idle after the final record")
  `RQS_ASSERT_IMP(a_load_on_accept, clk_i, rst_ni, cmd.wr_en && (cmd.wr_src == WR_IN), s_axis_tvalid && s_axis_tready, "record written from input without a transfer")

endmodule
